>>> sv/ffd_pkg.sv
// Shared types and constants for the fax frame deframer.
// No dependencies; every other file refers to this package by scoped names.

package ffd_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SYNC    = 2'd0;
  localparam logic [1:0] REG_CONTROL = 2'd1;
  localparam logic [1:0] REG_ADDRESS = 2'd2;
  localparam logic [1:0] REG_CHECK   = 2'd3;

  // Parser phases
  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_CTRL  = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_BODY  = 3'd5;
  localparam logic [2:0] PH_CHECK = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HDR_BAD  = 2'd1;
  localparam logic [1:0] ST_CSUM_BAD = 2'd2;

  localparam logic [8:0] FULL_LEN = 9'd256;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] control_value;
    logic [7:0] address_value;
    logic       check_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_command;
    logic       payload_valid;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

endpackage

>>> sv/fax_frame_deframer.sv
// Top level of the fax frame deframer: input byte register, parser, result buffer.
// Depends on ffd_pkg, ffd_regs, ffd_parse, ffd_outq.
//
//  channel   signals                                      direction
//  input     valid, ready, rx_byte                        in  (ready out)
//  output    out_valid, out_ready, payload_byte, is_command,
//            payload_valid, frame_end, status             out (out_ready in)
//  config    psel, penable, pwrite, paddr, pwdata, prdata, pready  APB slave
//
// One byte a cycle sustained, unless the input stage stalls. A byte is registered
// on accept, parsed in the next cycle, and its result (if any) is written into a
// two-entry buffer as the held byte is consumed. The input stage stalls
// only when the held byte makes a result and the buffer is full; bytes with no
// result never stall. Reset clears parser state, buffer and registers.

module fax_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        is_command,
  output logic        payload_valid,
  output logic        frame_end,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ffd_pkg::cfg_t cfg;
  ffd_pkg::res_t res;
  ffd_pkg::res_t out_res;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       res_valid;
  logic       has_room;
  logic       advance;
  logic [1:0] level;

  ffd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance = held_valid && (!res_valid || has_room);
  assign ready   = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ready) begin
      held_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) held_byte <= rx_byte;
  end

  ffd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (held_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ffd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_res  (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .level     (level)
  );

  assign payload_byte  = out_res.payload_byte;
  assign is_command    = out_res.is_command;
  assign payload_valid = out_res.payload_valid;
  assign frame_end     = out_res.frame_end;
  assign status        = out_res.status;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("result buffer overfilled");

  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ffd_pkg::ST_OK) |-> (frame_end && !payload_valid))
    else $error("error result without frame end or with payload");

  a_cmd_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_command) |-> payload_valid)
    else $error("command flag on a status-only result");

  a_held_stall: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !advance) |=> (held_valid && $stable(held_byte)))
    else $error("held byte lost while stalled");

endmodule

>>> sv/ffd_regs.sv
// APB configuration registers of the fax frame deframer.
// Depends on ffd_pkg (cfg_t, register indexes).

module ffd_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ffd_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ffd_pkg::REG_SYNC:    cfg.sync_value    <= pwdata[7:0];
        ffd_pkg::REG_CONTROL: cfg.control_value <= pwdata[7:0];
        ffd_pkg::REG_ADDRESS: cfg.address_value <= pwdata[7:0];
        ffd_pkg::REG_CHECK:   cfg.check_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ffd_pkg::REG_SYNC:    prdata = {24'd0, cfg.sync_value};
      ffd_pkg::REG_CONTROL: prdata = {24'd0, cfg.control_value};
      ffd_pkg::REG_ADDRESS: prdata = {24'd0, cfg.address_value};
      ffd_pkg::REG_CHECK:   prdata = {31'd0, cfg.check_enable};
      default:              prdata = '0;
    endcase
  end

endmodule

>>> sv/ffd_parse.sv
// Frame parser: header check, length count, body pass-through, checksum.
// Depends on ffd_pkg. State advances only when the held byte is consumed.

module ffd_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  ffd_pkg::cfg_t   cfg,
  output logic            res_valid,
  output ffd_pkg::res_t   res
);

  logic [2:0] phase, phase_next;
  logic       header_bad, header_bad_next;
  logic [8:0] bytes_left, bytes_left_next;
  logic       first_pending, first_pending_next;
  logic [7:0] running_sum, running_sum_next;
  logic [8:0] left_dec;
  logic [7:0] expect_sum;

  assign left_dec   = (bytes_left != 9'd0) ? bytes_left - 9'd1 : bytes_left;
  assign expect_sum = 8'd0 - running_sum;

  always_comb begin
    phase_next         = phase;
    header_bad_next    = header_bad;
    bytes_left_next    = bytes_left;
    first_pending_next = first_pending;
    running_sum_next   = running_sum;
    res_valid          = 1'b0;
    res                = '0;
    unique case (phase)
      ffd_pkg::PH_SYNC2: begin
        if (rx_byte != cfg.sync_value) header_bad_next = 1'b1;
        phase_next = ffd_pkg::PH_CTRL;
      end
      ffd_pkg::PH_CTRL: begin
        if (rx_byte != cfg.control_value) header_bad_next = 1'b1;
        running_sum_next = rx_byte;
        phase_next       = ffd_pkg::PH_ADDR;
      end
      ffd_pkg::PH_ADDR: begin
        if (rx_byte != cfg.address_value) header_bad_next = 1'b1;
        running_sum_next = running_sum + rx_byte;
        phase_next       = ffd_pkg::PH_LEN;
      end
      ffd_pkg::PH_LEN: begin
        if (header_bad) begin
          header_bad_next = 1'b0;
          phase_next      = ffd_pkg::PH_SYNC1;
          res_valid       = 1'b1;
          res.frame_end   = 1'b1;
          res.status      = ffd_pkg::ST_HDR_BAD;
        end else begin
          running_sum_next   = running_sum + rx_byte;
          // length 0 means a full 256-byte body
          bytes_left_next    = (rx_byte == 8'd0) ? ffd_pkg::FULL_LEN : {1'b0, rx_byte};
          first_pending_next = 1'b1;
          phase_next         = ffd_pkg::PH_BODY;
        end
      end
      ffd_pkg::PH_BODY: begin
        first_pending_next = 1'b0;
        running_sum_next   = running_sum + rx_byte;
        bytes_left_next    = left_dec;
        res_valid          = 1'b1;
        res.payload_byte   = rx_byte;
        res.is_command     = first_pending;
        res.payload_valid  = 1'b1;
        res.status         = ffd_pkg::ST_OK;
        if (left_dec == 9'd0) begin
          if (cfg.check_enable) begin
            phase_next = ffd_pkg::PH_CHECK;
          end else begin
            phase_next    = ffd_pkg::PH_SYNC1;
            res.frame_end = 1'b1;
          end
        end
      end
      ffd_pkg::PH_CHECK: begin
        phase_next    = ffd_pkg::PH_SYNC1;
        res_valid     = 1'b1;
        res.frame_end = 1'b1;
        res.status    = (rx_byte == expect_sum) ? ffd_pkg::ST_OK : ffd_pkg::ST_CSUM_BAD;
      end
      default: begin
        // first sync byte (unused code 7 lands here too)
        header_bad_next = (rx_byte != cfg.sync_value);
        phase_next      = ffd_pkg::PH_SYNC2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ffd_pkg::PH_SYNC1;
      header_bad    <= 1'b0;
      bytes_left    <= '0;
      first_pending <= 1'b0;
      running_sum   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      header_bad    <= header_bad_next;
      bytes_left    <= bytes_left_next;
      first_pending <= first_pending_next;
      running_sum   <= running_sum_next;
    end
  end

endmodule

>>> sv/ffd_outq.sv
// Two-entry result buffer between the parser and the output channel.
// Depends on ffd_pkg (res_t). Space is judged from the count alone.

module ffd_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ffd_pkg::res_t   push_res,
  output logic            has_room,
  output logic            out_valid,
  input  logic            out_ready,
  output ffd_pkg::res_t   out_res,
  output logic [1:0]      level
);

  ffd_pkg::res_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rd_ptr];
  assign level     = count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> bench/ffd_checker.sv
`timescale 1ns / 1ps
// Checker for the fax frame deframer. It watches the input, output and APB channels,
// predicts each result, and compares it with the DUT. Depends on ffd_pkg.

module ffd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  payload_byte,
  input  logic        is_command,
  input  logic        payload_valid,
  input  logic        frame_end,
  input  logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output logic        hunting
);

  ffd_pkg::cfg_t cfg;
  logic [2:0]    phase;
  logic          hdr_bad;
  logic [8:0]    body_left;
  logic          cmd_next;
  logic [7:0]    run_sum;
  ffd_pkg::res_t frame_results[$];

  // parser is partway through a frame
  assign hunting = (phase != ffd_pkg::PH_SYNC1);

  // Advance the parser by one line byte; returns 1 when the byte makes a result.
  function automatic bit deframe_byte(input logic [7:0] b, output ffd_pkg::res_t r);
    r = '0;
    case (phase)
      ffd_pkg::PH_SYNC2: begin
        if (b != cfg.sync_value) hdr_bad = 1'b1;
        phase = ffd_pkg::PH_CTRL;
        return 1'b0;
      end
      ffd_pkg::PH_CTRL: begin
        if (b != cfg.control_value) hdr_bad = 1'b1;
        run_sum = b;
        phase = ffd_pkg::PH_ADDR;
        return 1'b0;
      end
      ffd_pkg::PH_ADDR: begin
        if (b != cfg.address_value) hdr_bad = 1'b1;
        run_sum = run_sum + b;
        phase = ffd_pkg::PH_LEN;
        return 1'b0;
      end
      ffd_pkg::PH_LEN: begin
        if (hdr_bad) begin
          // length byte is dropped, hunt restarts on the next byte
          hdr_bad = 1'b0;
          phase = ffd_pkg::PH_SYNC1;
          r.frame_end = 1'b1;
          r.status = ffd_pkg::ST_HDR_BAD;
          return 1'b1;
        end
        run_sum = run_sum + b;
        body_left = (b == 8'd0) ? ffd_pkg::FULL_LEN : {1'b0, b};
        cmd_next = 1'b1;
        phase = ffd_pkg::PH_BODY;
        return 1'b0;
      end
      ffd_pkg::PH_BODY: begin
        r.payload_byte = b;
        r.is_command = cmd_next;
        r.payload_valid = 1'b1;
        r.status = ffd_pkg::ST_OK;
        cmd_next = 1'b0;
        run_sum = run_sum + b;
        if (body_left != 9'd0) body_left = body_left - 9'd1;
        if (body_left == 9'd0) begin
          if (cfg.check_enable) begin
            phase = ffd_pkg::PH_CHECK;
          end else begin
            phase = ffd_pkg::PH_SYNC1;
            r.frame_end = 1'b1;
          end
        end
        return 1'b1;
      end
      ffd_pkg::PH_CHECK: begin
        phase = ffd_pkg::PH_SYNC1;
        r.frame_end = 1'b1;
        r.status = (b == 8'd0 - run_sum) ? ffd_pkg::ST_OK : ffd_pkg::ST_CSUM_BAD;
        return 1'b1;
      end
      default: begin
        hdr_bad = (b != cfg.sync_value);
        phase = ffd_pkg::PH_SYNC2;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0h got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    ffd_pkg::res_t want;
    if (rst) begin
      cfg = '0;
      phase = ffd_pkg::PH_SYNC1;
      hdr_bad = 1'b0;
      body_left = '0;
      cmd_next = 1'b0;
      run_sum = '0;
      frame_results.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ffd_pkg::REG_SYNC:    cfg.sync_value = pwdata[7:0];
          ffd_pkg::REG_CONTROL: cfg.control_value = pwdata[7:0];
          ffd_pkg::REG_ADDRESS: cfg.address_value = pwdata[7:0];
          ffd_pkg::REG_CHECK:   cfg.check_enable = pwdata[0];
          default: ;
        endcase
      end
      if (valid && ready) begin
        if (deframe_byte(rx_byte, want)) frame_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          $error("unexpected result beat: payload_byte %0h status %0d", payload_byte, status);
          errors++;
        end else begin
          want = frame_results.pop_front();
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("is_command", want.is_command, is_command);
          check_field("payload_valid", want.payload_valid, payload_valid);
          check_field("frame_end", want.frame_end, frame_end);
          check_field("status", want.status, status);
        end
      end
    end
    pending = frame_results.size();
  end

endmodule

>>> bench/tb_fax_frame_deframer.sv
`timescale 1ns / 1ps
// Testbench top for the fax frame deframer: clock, reset, APB setup, byte stimulus
// and verdict. Depends on ffd_pkg, fax_frame_deframer and ffd_checker.

module tb_fax_frame_deframer;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        is_command;
  logic        payload_valid;
  logic        frame_end;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int   errors;
  int   pending;
  logic hunting;

  int src_idle_pct = 36;
  int sink_idle_pct = 74;
  int bytes_sent = 0;

  // shadow of the programmed header, used to build frames
  logic [7:0] sync_cfg = 8'd0;
  logic [7:0] ctrl_cfg = 8'd0;
  logic [7:0] addr_cfg = 8'd0;
  logic       check_cfg = 1'b0;

  fax_frame_deframer u_top (
    .clk(clk), .rst(rst),
    .valid(valid), .ready(ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .payload_byte(payload_byte),
    .is_command(is_command), .payload_valid(payload_valid), .frame_end(frame_end),
    .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ffd_checker u_checker (
    .clk(clk), .rst(rst),
    .valid(valid), .ready(ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .payload_byte(payload_byte),
    .is_command(is_command), .payload_valid(payload_valid), .frame_end(frame_end),
    .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .hunting(hunting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= sink_idle_pct);

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Upper pwdata bits carry junk; the register must keep only its own width.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & ~32'hFF) | {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      ffd_pkg::REG_SYNC:    sync_cfg = value;
      ffd_pkg::REG_CONTROL: ctrl_cfg = value;
      ffd_pkg::REG_ADDRESS: addr_cfg = value;
      ffd_pkg::REG_CHECK:   check_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Stop sending, wait for every predicted result, then let in-flight bytes clear.
  task automatic drain_results();
    valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_frame(input int len, input bit hdr_ok, input bit csum_ok);
    logic [7:0] hdr [4];
    logic [7:0] sum;
    logic [7:0] b;
    int         bad_pos;
    // flush any partial frame left by noise
    while (hunting) send_byte(8'($urandom));
    hdr[0] = sync_cfg;
    hdr[1] = sync_cfg;
    hdr[2] = ctrl_cfg;
    hdr[3] = addr_cfg;
    if (!hdr_ok) begin
      bad_pos = $urandom_range(3);
      hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(1, 255));
    end
    foreach (hdr[i]) send_byte(hdr[i]);
    sum = hdr[2] + hdr[3] + 8'(len);
    send_byte(8'(len));
    if (hdr_ok) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        sum = sum + b;
        send_byte(b);
      end
      if (check_cfg)
        send_byte(csum_ok ? 8'd0 - sum : (8'd0 - sum) ^ 8'($urandom_range(1, 255)));
    end
  endtask

  // Mostly good frames, some bad headers, some raw noise.
  task automatic random_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 72)
        send_frame($urandom_range(1, 12), 1'b1, $urandom_range(9) != 0);
      else if (pick < 88)
        send_frame($urandom_range(1, 12), 1'b0, 1'b1);
      else
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  task automatic program_random(input logic check_on);
    write_reg(ffd_pkg::REG_SYNC, 8'($urandom));
    write_reg(ffd_pkg::REG_CONTROL, 8'($urandom));
    write_reg(ffd_pkg::REG_ADDRESS, 8'($urandom));
    write_reg(ffd_pkg::REG_CHECK, {7'($urandom), check_on});
  endtask

  initial begin
    logic [7:0] seq[$];
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(ffd_pkg::REG_SYNC, 8'hFF);
    write_reg(ffd_pkg::REG_CONTROL, 8'h00);
    write_reg(ffd_pkg::REG_ADDRESS, 8'hFF);
    write_reg(ffd_pkg::REG_CHECK, 8'h01);
    // one-byte frame with good check, two-byte frame with bad check, bad control byte
    seq = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h01,
            8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h02, 8'h00, 8'h80, 8'h00,
            8'hFF, 8'hFF, 8'h01, 8'hFF, 8'h07};
    foreach (seq[i]) send_byte(seq[i]);
    drain_results();

    write_reg(ffd_pkg::REG_SYNC, 8'h00);
    write_reg(ffd_pkg::REG_CONTROL, 8'hFF);
    write_reg(ffd_pkg::REG_ADDRESS, 8'h00);
    write_reg(ffd_pkg::REG_CHECK, 8'hFE);
    // checking off: last body beat closes the frame
    seq = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h02, 8'h7F, 8'h01};
    foreach (seq[i]) send_byte(seq[i]);
    drain_results();

    program_random(1'b1);
    random_traffic(30);
    drain_results();
    random_traffic(30);
    drain_results();

    src_idle_pct = 74;
    sink_idle_pct = 36;
    program_random(1'b0);
    random_traffic(50);
    drain_results();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    program_random(1'b1);
    send_frame(256, 1'b1, 1'b1);
    send_frame(3, 1'b1, 1'b0);
    random_traffic(10);
    drain_results();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
